// ===== rtl/bsm_pkg.sv =====
// Shared types and constants of the battery sag monitor.
// Depends on nothing; imported by bsm_bank and battery_sag_monitor.
package bsm_pkg;

	// number of drop-factor candidates in the energy bank, 2..16
	localparam int CANDIDATES = 12;
	localparam int IDX_W      = $clog2(CANDIDATES);
	localparam int MV_W       = 35;

	localparam logic [15:0] LPF_K   = 16'd65325;      // 0.9968 in Q0.16
	localparam logic [7:0]  LPF_W   = 8'd211;         // 65536 - LPF_K
	localparam logic [15:0] V_CELL  = 16'd8602;       // 4.2 V, Q5.11
	localparam logic [15:0] V_MIN   = 16'd5530;       // 2.7 V, Q5.11
	localparam logic [15:0] THR_MIN = 16'd1638;       // 0.1, Q2.14
	// floor(y/5) == (y * RECIP5) >> 34 for any 32-bit y
	localparam logic [31:0] RECIP5  = 32'd3435973837;

	localparam logic [2:0] CFG_CELL_COUNT   = 3'd0;
	localparam logic [2:0] CFG_LOW_THRESH   = 3'd1;
	localparam logic [2:0] CFG_HYSTERESIS   = 3'd2;
	localparam logic [2:0] CFG_FIXED_DROP   = 3'd3;
	localparam logic [2:0] CFG_AUTO_DROP    = 3'd4;
	localparam logic [2:0] CFG_MODEL_COEFF  = 3'd5;
	localparam logic [2:0] CFG_HPF_COEFF    = 3'd6;
	localparam logic [2:0] CFG_SCORE_COEFF  = 3'd7;

	typedef struct packed {
		logic [31:0] score;
		logic [31:0] last_out;
		logic [31:0] last_in;
	} bank_ent_t;

	typedef struct packed {
		logic                   start;
		logic signed [MV_W-1:0] model_v;
		logic [31:0]            thrust;
		logic [15:0]            hpf_coeff;
		logic [15:0]            score_coeff;
	} bank_req_t;

	typedef struct packed {
		logic       done;
		logic [3:0] best;
	} bank_rsp_t;

endpackage

// ===== rtl/bsm_bank.sv =====
// Candidate energy bank: one memory entry per drop-factor candidate,
// one candidate updated per run, argmin sweep after the last. Uses bsm_pkg.
module bsm_bank import bsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bank_req_t req,
	output bank_rsp_t rsp
);

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_DIV  = 4'd1;
	localparam logic [3:0] B_CAND = 4'd2;
	localparam logic [3:0] B_FB   = 4'd3;
	localparam logic [3:0] B_ANS  = 4'd4;
	localparam logic [3:0] B_SQ   = 4'd5;
	localparam logic [3:0] B_SC0  = 4'd6;
	localparam logic [3:0] B_SC1  = 4'd7;
	localparam logic [3:0] B_RD   = 4'd8;
	localparam logic [3:0] B_CMP  = 4'd9;
	localparam logic [3:0] B_DONE = 4'd10;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(CANDIDATES - 1);

	logic [3:0]             state_q;
	logic [IDX_W-1:0]       slot_q, z_q, idx_q, arg_q, rd_addr;
	logic [3:0]             best_q;
	logic                   first_q;
	logic [CANDIDATES-1:0]  touched_q;
	logic signed [31:0]     seed_q, vc_q, li_q, ans_q;
	logic [IDX_W+31:0]      p_q;
	logic [63:0]            q_q;
	logic signed [48:0]     fb_q;
	logic [31:0]            score_q, sq_q, min_q;
	logic [49:0]            acc_q;

	bank_ent_t              mem [CANDIDATES];
	bank_ent_t              rd_q;

	logic signed [35:0]     cand_sum, cand_adj;
	logic signed [48:0]     fb_adj;
	logic signed [34:0]     ans_sum;
	logic [31:0]            ans_abs, scan_val, new_score;
	logic [63:0]            sq_full;
	logic [49:0]            sc_sum;
	logic                   take;
	logic [IDX_W-1:0]       fin_arg;
	logic [IDX_W:0]         fin_best;

	always_comb begin
		unique case (state_q)
			B_IDLE:       rd_addr = slot_q;
			B_RD, B_CMP:  rd_addr = idx_q;
			default:      rd_addr = z_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (state_q == B_SC1) begin
			mem[z_q] <= '{score: new_score, last_out: ans_q, last_in: vc_q};
		end
	end

	// candidate value, truncated toward zero on the divide by 256
	assign cand_sum = 36'(req.model_v) + $signed({6'b0, q_q[63:34]});
	assign cand_adj = cand_sum + $signed({28'b0, {8{cand_sum[35]}}});

	assign fb_adj  = fb_q + $signed({33'b0, {16{fb_q[48]}}});
	assign ans_sum = 35'(vc_q) - 35'(li_q) + 35'($signed(fb_adj[48:16]));

	assign ans_abs = ans_q[31] ? 32'(-ans_q) : 32'(ans_q);
	assign sq_full = 64'(ans_abs) * 64'(ans_abs);

	assign sc_sum    = acc_q + 50'(sq_q) * 50'(17'h10000 - 17'(req.score_coeff));
	assign new_score = sc_sum[47:16];

	assign scan_val = touched_q[idx_q] ? rd_q.score : 32'd0;
	assign take     = (idx_q == '0) || (scan_val < min_q);
	assign fin_arg  = take ? idx_q : arg_q;
	assign fin_best = (IDX_W+1)'(fin_arg) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			slot_q    <= '0;
			best_q    <= '0;
			first_q   <= 1'b1;
			touched_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (req.start) begin
						state_q <= B_DIV;
					end
				end
				B_DIV:  state_q <= B_CAND;
				B_CAND: state_q <= B_FB;
				B_FB: begin
					first_q <= 1'b0;
					state_q <= B_ANS;
				end
				B_ANS:  state_q <= B_SQ;
				B_SQ:   state_q <= B_SC0;
				B_SC0:  state_q <= B_SC1;
				B_SC1: begin
					touched_q[z_q] <= 1'b1;
					if (z_q == LAST) begin
						slot_q  <= '0;
						state_q <= B_RD;
					end else begin
						slot_q  <= z_q + 1'b1;
						state_q <= B_DONE;
					end
				end
				B_RD:   state_q <= B_CMP;
				B_CMP: begin
					if (idx_q == LAST) begin
						best_q  <= (fin_best > 15) ? 4'd15 : 4'(fin_best);
						state_q <= B_DONE;
					end else begin
						state_q <= B_RD;
					end
				end
				B_DONE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				z_q <= slot_q;
				p_q <= (IDX_W+32)'(slot_q) * (IDX_W+32)'(req.thrust);
			end
			B_DIV:  q_q <= 64'(p_q >> 4) * 64'(RECIP5);
			B_CAND: vc_q <= 32'(cand_adj >>> 8);
			B_FB: begin
				if (touched_q[z_q]) begin
					li_q    <= rd_q.last_in;
					fb_q    <= $signed({33'b0, req.hpf_coeff}) * 49'($signed(rd_q.last_out));
					score_q <= rd_q.score;
				end else begin
					li_q    <= first_q ? vc_q : seed_q;
					fb_q    <= '0;
					score_q <= '0;
				end
				if (first_q) begin
					seed_q <= vc_q;
				end
			end
			B_ANS: begin
				if (ans_sum > 35'sh7FFFFFFF) begin
					ans_q <= 32'sh7FFFFFFF;
				end else if (ans_sum < -35'sh80000000) begin
					ans_q <= 32'sh80000000;
				end else begin
					ans_q <= 32'(ans_sum);
				end
			end
			B_SQ:   sq_q  <= (|sq_full[63:48]) ? 32'hFFFF_FFFF : sq_full[47:16];
			B_SC0:  acc_q <= 50'(score_q) * 50'(req.score_coeff);
			B_SC1:  idx_q <= '0;
			B_CMP: begin
				if (take) begin
					min_q <= scan_val;
					arg_q <= idx_q;
				end
				idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == B_DONE);
	assign rsp.best = best_q;

endmodule

// ===== rtl/battery_sag_monitor.sv =====
// Top level of the battery sag monitor: stream ports, configuration
// registers, filter and compensation datapath. Uses bsm_pkg and bsm_bank.
//
// One item in, one item out. An item carries a battery reading, a supply
// reference reading and the motor thrust; the block low-pass filters the
// reference, the thrust and the reference-scaled voltage, applies the cell
// model, and returns the sag-compensated voltage, the filtered voltage, a
// hysteretic low-battery flag and the drop index. The candidate bank stays
// idle when auto mode is off or the filtered thrust is at or below 0.1;
// otherwise it updates one candidate per item, and the item that closes a
// bank sweep also waits while the argmin reads every score from the bank
// memory. The sequencer handles one item at a time and uses one multiplier
// per step; s_tready is high only between items and rises again right
// after the result is loaded into the output register, while the result
// register lets the next item in before the previous result is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, which the block does not enforce.
module battery_sag_monitor import bsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // battery_reading, reference_reading, thrust_sum
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // compensated_voltage, filtered_voltage,
	                                // low_battery, drop_index, zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCALE = 4'd1;
	localparam logic [3:0] S_REF0  = 4'd2;
	localparam logic [3:0] S_REF1  = 4'd3;
	localparam logic [3:0] S_THR0  = 4'd4;
	localparam logic [3:0] S_THR1  = 4'd5;
	localparam logic [3:0] S_MOD0  = 4'd6;
	localparam logic [3:0] S_MOD1  = 4'd7;
	localparam logic [3:0] S_VF0   = 4'd8;
	localparam logic [3:0] S_VF1   = 4'd9;
	localparam logic [3:0] S_MV    = 4'd10;
	localparam logic [3:0] S_GO    = 4'd11;
	localparam logic [3:0] S_BANK  = 4'd12;
	localparam logic [3:0] S_DROP0 = 4'd13;
	localparam logic [3:0] S_DROP1 = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	// configuration registers
	logic [2:0]  cell_count_q;
	logic [15:0] low_threshold_q;
	logic [11:0] hysteresis_q;
	logic [7:0]  fixed_drop_q;
	logic        auto_drop_q;
	logic [15:0] model_coeff_q, hpf_coeff_q, score_coeff_q;

	// filter state
	logic [31:0] ref_f_q, thr_f_q, vf_q;
	logic        low_flag_q;

	// per-item working registers
	logic [3:0]             state_q;
	logic [15:0]            batt_q, refr_q, thr_q, scaled_q, cellv_q;
	logic [49:0]            acc_q;
	logic [31:0]            mref_q;
	logic signed [MV_W-1:0] mv_q;
	logic [39:0]            dx_q;
	logic [63:0]            dq_q;

	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	bank_req_t req;
	bank_rsp_t rsp;

	logic [47:0]        scale_p;
	logic signed [32:0] vdiff, vdiff_adj;
	logic               bank_go;
	logic [32:0]        drop;
	logic signed [36:0] comp_sum;
	logic [36:0]        limit;
	logic [16:0]        thresh;
	logic               low;
	logic [15:0]        comp_out;
	logic               out_load;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign req.start       = (state_q == S_GO) && bank_go;
	assign req.model_v     = mv_q;
	assign req.thrust      = thr_f_q;
	assign req.hpf_coeff   = hpf_coeff_q;
	assign req.score_coeff = score_coeff_q;

	bsm_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// scaled battery sample uses the reference filter value before its update
	assign scale_p = 48'(batt_q) * 48'(ref_f_q);

	// model voltage: v + (v - model)/4, divide truncating toward zero
	assign vdiff     = $signed({1'b0, vf_q}) - $signed({1'b0, mref_q});
	assign vdiff_adj = vdiff + $signed({31'b0, {2{vdiff[32]}}});

	assign bank_go = auto_drop_q && (thr_f_q > {THR_MIN, 16'b0});

	// auto: best * thrust / 80 via reciprocal of 5; fixed: Q1.7 factor * thrust
	assign drop = auto_drop_q ? {3'b0, dq_q[63:34]} : dx_q[39:7];

	// comp = model voltage + drop; drop is final once S_DROP1 has run
	assign comp_sum = 37'(mv_q) + $signed({4'b0, drop});

	assign thresh = 17'(low_threshold_q) + 17'(low_flag_q ? hysteresis_q : 12'd0);
	assign limit  = {4'b0, thresh, 16'b0};
	assign low    = (comp_sum < $signed(limit)) || (vf_q < {V_MIN, 16'b0});

	always_comb begin
		if (comp_sum[36]) begin
			comp_out = 16'd0;
		end else if (|comp_sum[35:32]) begin
			comp_out = 16'hFFFF;
		end else begin
			comp_out = comp_sum[31:16];
		end
	end

	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q    <= 3'd1;
			low_threshold_q <= 16'd7168;
			hysteresis_q    <= 12'd102;
			fixed_drop_q    <= 8'd0;
			auto_drop_q     <= 1'b1;
			model_coeff_q   <= 16'd65514;
			hpf_coeff_q     <= 16'd64754;
			score_coeff_q   <= 16'd65457;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CELL_COUNT:  cell_count_q    <= cfg_data[2:0];
				CFG_LOW_THRESH:  low_threshold_q <= cfg_data;
				CFG_HYSTERESIS:  hysteresis_q    <= cfg_data[11:0];
				CFG_FIXED_DROP:  fixed_drop_q    <= cfg_data[7:0];
				CFG_AUTO_DROP:   auto_drop_q     <= cfg_data[0];
				CFG_MODEL_COEFF: model_coeff_q   <= cfg_data;
				CFG_HPF_COEFF:   hpf_coeff_q     <= cfg_data;
				CFG_SCORE_COEFF: score_coeff_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ref_f_q    <= 32'h1000_0000;
			thr_f_q    <= '0;
			vf_q       <= '0;
			low_flag_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_REF0;
				S_REF0:  state_q <= S_REF1;
				S_REF1: begin
					ref_f_q <= 32'((acc_q + 50'({refr_q, 16'b0}) * 50'(LPF_W)) >> 16);
					state_q <= S_THR0;
				end
				S_THR0:  state_q <= S_THR1;
				S_THR1: begin
					thr_f_q <= 32'((acc_q + 50'({thr_q, 16'b0}) * 50'(LPF_W)) >> 16);
					state_q <= S_MOD0;
				end
				S_MOD0:  state_q <= S_MOD1;
				S_MOD1:  state_q <= S_VF0;
				S_VF0:   state_q <= S_VF1;
				S_VF1: begin
					vf_q    <= 32'((acc_q + 50'({scaled_q, 16'b0}) * 50'(LPF_W)) >> 16);
					state_q <= S_MV;
				end
				S_MV:    state_q <= S_GO;
				S_GO:    state_q <= bank_go ? S_BANK : S_DROP0;
				S_BANK: begin
					if (rsp.done) begin
						state_q <= S_DROP0;
					end
				end
				S_DROP0: state_q <= S_DROP1;
				S_DROP1: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						low_flag_q <= low;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			batt_q <= s_tdata[15:0];
			refr_q <= s_tdata[31:16];
			thr_q  <= s_tdata[47:32];
		end
		if (out_load) begin
			m_tdata_q <= {3'b0, rsp.best, low, vf_q[31:16], comp_out};
		end
		unique case (state_q)
			S_SCALE: begin
				scaled_q <= (|scale_p[47:44]) ? 16'hFFFF : scale_p[43:28];
				cellv_q  <= 16'(V_CELL * cell_count_q);
			end
			S_REF0: acc_q <= 50'(ref_f_q) * 50'(LPF_K);
			S_THR0: acc_q <= 50'(thr_f_q) * 50'(LPF_K);
			S_MOD0: acc_q <= 50'({cellv_q, 16'b0}) * 50'(model_coeff_q);
			S_MOD1: acc_q <= acc_q + 50'(vf_q) * 50'(17'h10000 - 17'(model_coeff_q));
			S_VF0: begin
				mref_q <= acc_q[47:16];
				acc_q  <= 50'(vf_q) * 50'(LPF_K);
			end
			S_MV: mv_q <= $signed({3'b0, vf_q}) + MV_W'(vdiff_adj >>> 2);
			S_DROP0: begin
				dx_q <= auto_drop_q ? 40'(rsp.best) * 40'(thr_f_q)
				                    : 40'(fixed_drop_q) * 40'(thr_f_q);
			end
			S_DROP1: dq_q <= 64'(dx_q[35:4]) * 64'(RECIP5);
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != S_IDLE)
		else $error("item accepted but sequencer stayed idle");

	a_done_in_bank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_BANK)
		else $error("bank finished while not awaited");

	a_flag_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[32] == low_flag_q)
		else $error("low battery output differs from flag state");
`endif

endmodule
